FILE: hdl/rita_pkg.sv
// ----------------------------------------------------------------------------
// rita_pkg: shared types and constants for the radix integer-to-ASCII block
// Holds the transaction structs, the controller state and command types and
// the digit-to-character mapping.
// ----------------------------------------------------------------------------
package rita_pkg;

  localparam int OPERAND_WIDTH       = 32;
  localparam int RADIX_WIDTH         = 5;
  localparam int CHAR_WIDTH          = 7;
  localparam int DIGIT_WIDTH         = 4;
  localparam int VALUE_WIDTH_DEFAULT = 32;
  // Quotient bits resolved per divider cycle.
  localparam int CHUNK_BITS          = 8;

  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 5'd16;

  typedef struct packed {
    logic [OPERAND_WIDTH-1:0] value;
    logic [RADIX_WIDTH-1:0]   radix;
  } operand_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] digit_char;
    logic                  last_digit;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic pop;
  } ctrl_cmd_t;

  typedef struct packed {
    logic digit_done;
    logic quot_zero;
    logic last_entry;
  } dp_status_t;

  // Map a digit value to its ASCII character: 0-9 then A-F.
  function automatic logic [CHAR_WIDTH-1:0] digit_char_of(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] c;
    if (d < 4'd10) begin
      c = 7'h30 + CHAR_WIDTH'(d);
    end else begin
      c = 7'h41 + CHAR_WIDTH'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

FILE: hdl/radix_integer_to_ascii.sv
// ----------------------------------------------------------------------------
// radix_integer_to_ascii: unsigned integer to ASCII digits in radix 2..16
// Converts one value per transaction and emits its digits most significant
// first, one result transaction per digit, the last one flagged.
// ----------------------------------------------------------------------------
//
//  channel   ports                      handshake
//  -------   -------------------------  -----------------------------------
//  operand   operand.value/.radix       taken at a clock edge with start
//                                       high and busy low
//  result    result.digit_char/.last_digit  each digit marked by
//                                         result_valid, always taken
//
// Steps: the operand is taken, then each digit is extracted by a shift for radix
// 2, 4, 8 or 16, or otherwise by long division over W = min(VALUE_WIDTH, 32)
// bits, with the divider resolving eight quotient bits a cycle; then the digits
// are emitted from the digit stack.
// Reset clears the sequencer, the stack count and result_valid; nothing else.
// The receiver cannot stall: each digit is shown for exactly one cycle.
// busy drops in the cycle the final digit is shown, so the next operand may
// be taken while it is still on the result ports.
//
module radix_integer_to_ascii #(
  parameter int VALUE_WIDTH = rita_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rita_pkg::operand_t operand,
  output logic               result_valid,
  output rita_pkg::result_t  result
);

  rita_pkg::ctrl_cmd_t  cmd;
  rita_pkg::dp_status_t status;

  // Sequencer: load, then divide until the quotient is zero, then emit.
  rita_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Divider, digit stack and registered result.
  rita_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .operand      (operand),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

FILE: hdl/rita_ctrl.sv
// ----------------------------------------------------------------------------
// rita_ctrl: conversion sequencer
// Accepts a transaction, steps the datapath until the quotient reaches zero,
// then pops the collected digits out most significant first.
// ----------------------------------------------------------------------------
module rita_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  rita_pkg::dp_status_t   status,
  output rita_pkg::ctrl_cmd_t    cmd,
  output logic                   busy
);

  rita_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rita_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      rita_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = rita_pkg::ST_DIVIDE;
        end
      end
      rita_pkg::ST_DIVIDE: begin
        cmd.step = 1'b1;
        // finish collecting once a digit completes with a zero quotient
        if (status.digit_done && status.quot_zero) begin
          state_next = rita_pkg::ST_EMIT;
        end
      end
      rita_pkg::ST_EMIT: begin
        cmd.pop = 1'b1;
        if (status.last_entry) begin
          state_next = rita_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rita_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/rita_datapath.sv
// ----------------------------------------------------------------------------
// rita_datapath: digit extraction and digit stack
// Long division by the radix, one chunk of quotient bits per cycle, with a
// shift path for power-of-two radices. Digits are pushed least significant
// first and popped into the registered result.
// ----------------------------------------------------------------------------
module rita_datapath #(
  parameter int VALUE_WIDTH = rita_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  rita_pkg::operand_t   operand,
  input  rita_pkg::ctrl_cmd_t  cmd,
  output rita_pkg::dp_status_t status,
  output logic                 result_valid,
  output rita_pkg::result_t    result
);

  localparam int EFF_W  = (VALUE_WIDTH < rita_pkg::OPERAND_WIDTH) ?
                          VALUE_WIDTH : rita_pkg::OPERAND_WIDTH;
  localparam int CB     = rita_pkg::CHUNK_BITS;
  localparam int NCHUNK = (EFF_W + CB - 1) / CB;
  localparam int PAD_W  = NCHUNK * CB;
  localparam int DEPTH  = EFF_W;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int DW     = rita_pkg::DIGIT_WIDTH;
  localparam int RW     = rita_pkg::RADIX_WIDTH;

  logic [PAD_W-1:0] work;
  logic [RW-1:0]    radix;
  logic [DW-1:0]    rem;
  logic [CHK_W-1:0] chunk;
  logic [CNT_W-1:0] count;
  logic [DW-1:0]    stack [DEPTH];

  logic [RW-1:0]    radix_clamped;
  logic             pow2;
  logic [2:0]       shamt;
  logic [CB-1:0]    qbits;
  logic [DW-1:0]    rem_final;
  logic [PAD_W-1:0] div_work_next;
  logic [PAD_W-1:0] step_work_next;
  logic [DW-1:0]    digit;
  logic             chunk_last;
  logic             digit_done;
  logic [CNT_W-1:0] top_cnt;

  // Clamp the requested radix into 2..16.
  always_comb begin
    if (operand.radix < rita_pkg::RADIX_MIN) begin
      radix_clamped = rita_pkg::RADIX_MIN;
    end else if (operand.radix > rita_pkg::RADIX_MAX) begin
      radix_clamped = rita_pkg::RADIX_MAX;
    end else begin
      radix_clamped = operand.radix;
    end
  end

  always_comb begin
    pow2  = 1'b0;
    shamt = 3'd1;
    case (radix)
      5'd2:    begin pow2 = 1'b1; shamt = 3'd1; end
      5'd4:    begin pow2 = 1'b1; shamt = 3'd2; end
      5'd8:    begin pow2 = 1'b1; shamt = 3'd3; end
      5'd16:   begin pow2 = 1'b1; shamt = 3'd4; end
      default: begin pow2 = 1'b0; shamt = 3'd1; end
    endcase
  end

  // One chunk of restoring division: the remainder stays below the radix.
  always_comb begin
    logic [DW-1:0] r_acc;
    logic [DW:0]   t;
    r_acc = rem;
    qbits = '0;
    for (int i = 0; i < CB; i++) begin
      t = {r_acc, work[PAD_W-1-i]};
      if (t >= radix) begin
        qbits[CB-1-i] = 1'b1;
        r_acc         = DW'(t - radix);
      end else begin
        r_acc = t[DW-1:0];
      end
    end
    rem_final = r_acc;
  end

  // Rotating each chunk out of the top leaves the quotient once all NCHUNK chunks have passed.
  assign div_work_next  = (work << CB) | PAD_W'(qbits);
  assign step_work_next = pow2 ? (work >> shamt) : div_work_next;
  assign digit          = pow2 ? (work[DW-1:0] & (radix[DW-1:0] - 1'b1)) : rem_final;
  assign chunk_last     = (chunk == CHK_W'(NCHUNK - 1));
  assign digit_done     = pow2 || chunk_last;
  assign top_cnt        = count - 1'b1;

  assign status.digit_done = cmd.step && digit_done;
  assign status.quot_zero  = (step_work_next == '0);
  assign status.last_entry = (count == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work  <= PAD_W'(operand.value[EFF_W-1:0]);
      radix <= radix_clamped;
      rem   <= '0;
      chunk <= '0;
    end else if (cmd.step) begin
      work <= step_work_next;
      if (!pow2) begin
        if (chunk_last) begin
          rem   <= '0;
          chunk <= '0;
        end else begin
          rem   <= rem_final;
          chunk <= chunk + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && digit_done) begin
      stack[count[IDX_W-1:0]] <= digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.pop;
      if (cmd.load) begin
        count <= '0;
      end else if (cmd.step && digit_done) begin
        count <= count + 1'b1;
      end else if (cmd.pop) begin
        count <= top_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      result.digit_char <= rita_pkg::digit_char_of(stack[top_cnt[IDX_W-1:0]]);
      result.last_digit <= (count == CNT_W'(1));
    end
  end

endmodule

FILE: test/radix_digit_checker.sv
// ----------------------------------------------------------------------------
// radix_digit_checker: scoreboard for the radix integer-to-ASCII block
// Watches the operand and result channels, predicts the digit characters of
// every accepted operand and compares each result transaction with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module radix_digit_checker #(
  parameter int VALUE_WIDTH = rita_pkg::VALUE_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  rita_pkg::operand_t operand,
  input  logic               result_valid,
  input  rita_pkg::result_t  result,
  output int                 mismatch_count,
  output int                 chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPERAND_WIDTH = rita_pkg::OPERAND_WIDTH;
  localparam int CHAR_WIDTH    = rita_pkg::CHAR_WIDTH;

  rita_pkg::result_t expected_chars[$];

  // Expand one operand into its digit characters, most significant first.
  function automatic void queue_digits(input rita_pkg::operand_t op);
    logic [OPERAND_WIDTH-1:0] v;
    logic [OPERAND_WIDTH-1:0] mask;
    logic [CHAR_WIDTH-1:0]    rev [32];
    int unsigned              base;
    int unsigned              d;
    int                       n;
    rita_pkg::result_t        item;
    mask = (VALUE_WIDTH >= OPERAND_WIDTH) ? '1
                                          : ((OPERAND_WIDTH'(1) << VALUE_WIDTH) - 1);
    v = op.value & mask;
    base = op.radix;
    if (base < 2) base = 2;
    if (base > 16) base = 16;
    n = 0;
    do begin
      d = v % base;
      rev[n] = (d < 10) ? CHAR_WIDTH'(48 + d) : CHAR_WIDTH'(55 + d);
      v = v / base;
      n++;
    end while (v != 0 && n < 32);
    for (int k = n - 1; k >= 0; k--) begin
      item.digit_char = rev[k];
      item.last_digit = (k == 0);
      expected_chars.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    rita_pkg::result_t want;
    if (rst) begin
      expected_chars.delete();
      mismatch_count <= 0;
      chars_pending  <= 0;
    end else begin
      if (result_valid) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected result: digit_char %0d last_digit %0d",
                 result.digit_char, result.last_digit);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_chars.pop_front();
          if (result.digit_char !== want.digit_char ||
              result.last_digit !== want.last_digit) begin
            if (result.digit_char !== want.digit_char)
              $error("digit_char: expected %0d, actual %0d",
                     want.digit_char, result.digit_char);
            if (result.last_digit !== want.last_digit)
              $error("last_digit: expected %0d, actual %0d",
                     want.last_digit, result.last_digit);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (start && !busy) queue_digits(operand);
      chars_pending <= expected_chars.size();
    end
  end

endmodule

FILE: test/tb_radix_integer_to_ascii.sv
// ----------------------------------------------------------------------------
// tb_radix_integer_to_ascii: testbench for the radix integer-to-ASCII block
// Drives directed and random operands with random hold-offs, leaves the
// checking to the digit checker and prints the verdict.
// ----------------------------------------------------------------------------
module tb_radix_integer_to_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPERAND_WIDTH  = rita_pkg::OPERAND_WIDTH;
  localparam int RADIX_WIDTH    = rita_pkg::RADIX_WIDTH;

  localparam int RANDOM_ITEMS   = 197;
  // Back-to-back stretch at the end of the run.
  localparam int STEADY_ITEMS   = 40;
  // Must outlast the slowest item (radix 3) plus the longest hold-off.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 120;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  rita_pkg::operand_t operand;
  logic               result_valid;
  rita_pkg::result_t  result;
  int                 mismatch_count;
  int                 chars_pending;
  int                 quiet_cycles;

  radix_integer_to_ascii dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operand      (operand),
    .result_valid (result_valid),
    .result       (result)
  );

  radix_digit_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operand        (operand),
    .result_valid   (result_valid),
    .result         (result),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: count cycles in which no transaction moves on either channel.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_radix_integer_to_ascii: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one operand at the falling edge and hold it until accepted.
  // start stays high on return so the next operand can follow back to back.
  task automatic send_operand(input logic [OPERAND_WIDTH-1:0] v,
                              input logic [RADIX_WIDTH-1:0] r);
    rita_pkg::operand_t op;
    op.value = v;
    op.radix = r;
    @(negedge clk);
    start   <= 1'b1;
    operand <= op;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start for a hold-off of length n.
  task automatic hold_off(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop start and wait until every predicted digit has come out.
  task automatic drain_digits();
    @(negedge clk);
    start <= 1'b0;
    while (chars_pending != 0) @(posedge clk);
  endtask

  // Mostly legal radixes; now and then any 5-bit code to hit the clamping.
  function automatic logic [RADIX_WIDTH-1:0] pick_radix();
    if ($urandom_range(0, 4) == 0) return RADIX_WIDTH'($urandom_range(0, 31));
    return RADIX_WIDTH'($urandom_range(2, 16));
  endfunction

  // Mix full-range values with small ones and digit-count boundaries.
  function automatic logic [OPERAND_WIDTH-1:0] pick_value(input logic [RADIX_WIDTH-1:0] r);
    longint unsigned p;
    int unsigned     base;
    int              k;
    base = r;
    if (base < 2) base = 2;
    if (base > 16) base = 16;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 300);
      2: begin
        // Radix power, or one below it: the digit count steps here.
        p = 1;
        k = $urandom_range(1, 31);
        while (k > 0 && p * base <= 64'hFFFF_FFFF) begin
          p = p * base;
          k--;
        end
        return OPERAND_WIDTH'(p - $urandom_range(0, 1));
      end
      3: return 32'h1 << $urandom_range(0, 31);
      4: return $urandom() >> $urandom_range(0, 31);
      default: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    endcase
  endfunction

  initial begin
    logic [RADIX_WIDTH-1:0]   r;
    logic [OPERAND_WIDTH-1:0] v;
    rst     <= 1'b1;
    start   <= 1'b0;
    operand <= '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero, all ones, radix extremes, clamped radix codes, letters.
    send_operand(32'h0000_0000, 5'd10);
    send_operand(32'h0000_0000, 5'd2);
    send_operand(32'hFFFF_FFFF, 5'd2);
    send_operand(32'hFFFF_FFFF, 5'd16);
    send_operand(32'hFFFF_FFFF, 5'd10);
    send_operand(32'hFFFF_FFFF, 5'd3);
    send_operand(32'h8000_0000, 5'd2);
    send_operand(32'h0000_0001, 5'd2);
    send_operand(32'h0000_000F, 5'd16);
    send_operand(32'h0000_000A, 5'd16);
    send_operand(32'h0000_0010, 5'd16);
    send_operand(32'hFEDC_BA98, 5'd16);
    send_operand(32'h0123_4567, 5'd16);
    send_operand(32'h3B9A_C9FF, 5'd10);
    send_operand(32'h0000_0009, 5'd10);
    // Radix codes below two act as two, above sixteen as sixteen.
    send_operand(32'h0000_00A5, 5'd0);
    send_operand(32'h0000_00A5, 5'd1);
    send_operand(32'hABCD_EF01, 5'd17);
    send_operand(32'hABCD_EF01, 5'd31);
    send_operand(32'h0000_0000, 5'd31);
    // Signed -12345 goes in as its bit pattern.
    send_operand(32'hFFFF_CFC7, 5'd10);
    send_operand(32'h0000_0030, 5'd7);
    send_operand(32'h7FFF_FFFF, 5'd15);

    // Random: occasional full drains, bursts of hold-off, steady tail.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0 && i < RANDOM_ITEMS - STEADY_ITEMS) drain_digits();
      r = pick_radix();
      v = pick_value(r);
      send_operand(v, r);
      if (i < RANDOM_ITEMS - STEADY_ITEMS && $urandom_range(0, 2) == 0)
        hold_off($urandom_range(1, 10));
    end

    drain_digits();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("tb_radix_integer_to_ascii: done, clean");
    end else begin
      $display("tb_radix_integer_to_ascii: done, errors");
    end
    $finish;
  end

endmodule
